/* rtl/core/kabf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter: shared package
// Word types, fixed-point helpers, register indexes, datapath micro-operations
// and the two micro-programs that the controller steps through.
// ----------------------------------------------------------------------------
package kabf_pkg;

  // Word and field widths.
  localparam int WORD_W    = 32;
  localparam int DT_W      = 16;
  localparam int NOISE_W   = 31;
  localparam int EXT_W     = WORD_W + 4;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_BITS  = 56;
  localparam int PRED_LEN  = 14;
  localparam int UPD_LEN   = 13;
  localparam int STEP_W    = 4;
  localparam int DIVCNT_W  = 6;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [EXT_W-1:0]  ext_t;

  // Reset values.
  localparam word_t              ONE_Q24           = 32'sd16777216;
  localparam logic [NOISE_W-1:0] DEF_ANGLE_NOISE   = 31'd16777;
  localparam logic [NOISE_W-1:0] DEF_BIAS_NOISE    = 31'd50332;
  localparam logic [NOISE_W-1:0] DEF_MEASURE_NOISE = 31'd503316;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 3'd3;

  // Datapath micro-operations. OP_M_* launch a multiply; the next one consumes it.
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_RATE,
    OP_M_DT_RATE,
    OP_ANGLE_ADD,
    OP_M_DT_P11,
    OP_DTP11,
    OP_M_DT_DTP11,
    OP_INNER,
    OP_M_DT_INNER,
    OP_P00_ADD,
    OP_OFFDIAG,
    OP_M_QB_DT,
    OP_P11_ADD,
    OP_INNOV,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_ROUND,
    OP_M_K0_Y,
    OP_ANGLE_K,
    OP_M_K1_Y,
    OP_BIAS_K,
    OP_M_K1_P00,
    OP_P10_K,
    OP_M_K1_P01,
    OP_P11_K,
    OP_M_K0_P00,
    OP_P00_K,
    OP_M_K0_P01,
    OP_P01_K,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic s_pos;
  } status_t;

  // Prediction program, ending with the innovation and the divider set-up.
  function automatic op_t pred_op(input logic [STEP_W-1:0] idx);
    op_t op;
    case (idx)
      4'd0:    op = OP_RATE;
      4'd1:    op = OP_M_DT_RATE;
      4'd2:    op = OP_ANGLE_ADD;
      4'd3:    op = OP_M_DT_P11;
      4'd4:    op = OP_DTP11;
      4'd5:    op = OP_M_DT_DTP11;
      4'd6:    op = OP_INNER;
      4'd7:    op = OP_M_DT_INNER;
      4'd8:    op = OP_P00_ADD;
      4'd9:    op = OP_OFFDIAG;
      4'd10:   op = OP_M_QB_DT;
      4'd11:   op = OP_P11_ADD;
      4'd12:   op = OP_INNOV;
      4'd13:   op = OP_DIV_INIT;
      default: op = OP_IDLE;
    endcase
    return op;
  endfunction

  // Correction program. The bias row goes first so that it sees the old angle row.
  function automatic op_t upd_op(input logic [STEP_W-1:0] idx);
    op_t op;
    case (idx)
      4'd0:    op = OP_DIV_ROUND;
      4'd1:    op = OP_M_K0_Y;
      4'd2:    op = OP_ANGLE_K;
      4'd3:    op = OP_M_K1_Y;
      4'd4:    op = OP_BIAS_K;
      4'd5:    op = OP_M_K1_P00;
      4'd6:    op = OP_P10_K;
      4'd7:    op = OP_M_K1_P01;
      4'd8:    op = OP_P11_K;
      4'd9:    op = OP_M_K0_P00;
      4'd10:   op = OP_P00_K;
      4'd11:   op = OP_M_K0_P01;
      4'd12:   op = OP_P01_K;
      default: op = OP_IDLE;
    endcase
    return op;
  endfunction

  // Sign extension to the wide sum format.
  function automatic ext_t ext(input word_t v);
    return EXT_W'(v);
  endfunction

  // Saturate a wide sum to one word.
  function automatic word_t sat_word(input ext_t v);
    word_t r;
    if (v > EXT_W'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (v < EXT_W'(32'sh80000000)) begin
      r = 32'sh80000000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Magnitude of a word; the most negative word gives 2^31.
  function automatic logic [WORD_W-1:0] mag_word(input word_t v);
    return v[WORD_W-1] ? (32'd0 - 32'(v)) : 32'(v);
  endfunction

  // Apply a sign to a magnitude and saturate to one word.
  function automatic word_t mag_sat(input logic neg, input logic [DIV_BITS-1:0] q);
    logic [WORD_W:0] n;
    word_t r;
    n = 33'd0 - q[WORD_W:0];
    if (neg) begin
      r = (q > 56'h80000000) ? 32'sh80000000 : word_t'(n[WORD_W-1:0]);
    end else begin
      r = (q > 56'h7fffffff) ? 32'sh7fffffff : word_t'(q[WORD_W-1:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/core/kabf_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter: measurement channel
// Valid/ready channel carrying one gyro rate, accelerometer angle and time step.
// ----------------------------------------------------------------------------
interface kabf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gyro_sample;
  logic signed [31:0] accel_tilt;
  logic        [15:0] time_step;

  modport source (output valid, gyro_sample, accel_tilt, time_step, input ready);
  modport sink   (input valid, gyro_sample, accel_tilt, time_step, output ready);
endinterface

/* rtl/core/kabf_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter: estimate channel
// Valid/ready channel carrying the angle and bias estimates of one update.
// ----------------------------------------------------------------------------
interface kabf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] drift_estimate;

  modport source (output valid, angle_estimate, drift_estimate, input ready);
  modport sink   (input valid, angle_estimate, drift_estimate, output ready);
endinterface

/* rtl/core/kabf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter: datapath
// Filter state, configuration registers, one shared 32x32 multiplier with a
// rounding and saturating back end, and a two-lane restoring divider for gains.
// ----------------------------------------------------------------------------
module kabf_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  kabf_pkg::cmd_t                     cmd,
  output kabf_pkg::status_t                  status,
  input  logic signed [31:0]                 gyro_sample,
  input  logic signed [31:0]                 accel_tilt,
  input  logic        [15:0]                 time_step,
  input  logic                               cfg_we,
  input  logic        [kabf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [31:0]                 cfg_wdata,
  output logic signed [31:0]                 angle_estimate,
  output logic signed [31:0]                 drift_estimate
);
  import kabf_pkg::*;

  // Configuration registers.
  logic [NOISE_W-1:0] qa_r, qb_r, rm_r;

  // Filter state and captured measurements.
  word_t            angle_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  word_t            gyro_r, accel_r;
  logic [DT_W-1:0]  dt_r;

  // Scratch registers: rate, inner term or innovation; dt*P11; S; gains.
  word_t tmp_r, dtp_r, s_r, k0_r, k1_r;

  // Multiplier pipeline register.
  logic [2*WORD_W-1:0] prod_r;
  logic                neg_r, sh24_r;

  // Divider lanes: lane 0 gives K0, lane 1 gives K1.
  logic [DIV_BITS-1:0] dd0_r, dd1_r, quo0_r, quo1_r;
  logic [WORD_W-1:0]   rem0_r, rem1_r;
  logic                dneg0_r, dneg1_r;

  // Result register.
  word_t out_angle_r, out_bias_r;

  word_t               dt_w, qa_w, qb_w, rm_w;
  word_t               mul_a, mul_b, mv;
  logic                mul_sh24;
  logic [2*WORD_W-1:0] rsum;
  logic [DIV_BITS-1:0] rq;
  logic [WORD_W:0]     t0, t1, two_r0, two_r1;
  logic                ge0, ge1;

  assign dt_w = word_t'({16'd0, dt_r});
  assign qa_w = word_t'({1'b0, qa_r});
  assign qb_w = word_t'({1'b0, qb_r});
  assign rm_w = word_t'({1'b0, rm_r});

  // Multiplier operand selection.
  always_comb begin
    mul_a    = dt_w;
    mul_b    = tmp_r;
    mul_sh24 = 1'b0;
    case (cmd.op)
      OP_M_DT_RATE:  begin mul_a = dt_w; mul_b = tmp_r; end
      OP_M_DT_P11:   begin mul_a = dt_w; mul_b = p11_r; end
      OP_M_DT_DTP11: begin mul_a = dt_w; mul_b = dtp_r; end
      OP_M_DT_INNER: begin mul_a = dt_w; mul_b = tmp_r; end
      OP_M_QB_DT:    begin mul_a = qb_w; mul_b = dt_w; end
      OP_M_K0_Y:     begin mul_a = k0_r; mul_b = tmp_r; mul_sh24 = 1'b1; end
      OP_M_K1_Y:     begin mul_a = k1_r; mul_b = tmp_r; mul_sh24 = 1'b1; end
      OP_M_K1_P00:   begin mul_a = k1_r; mul_b = p00_r; mul_sh24 = 1'b1; end
      OP_M_K1_P01:   begin mul_a = k1_r; mul_b = p01_r; mul_sh24 = 1'b1; end
      OP_M_K0_P00:   begin mul_a = k0_r; mul_b = p00_r; mul_sh24 = 1'b1; end
      OP_M_K0_P01:   begin mul_a = k0_r; mul_b = p01_r; mul_sh24 = 1'b1; end
      default:       begin mul_a = dt_w; mul_b = tmp_r; end
    endcase
  end

  // Product rounded to nearest (ties away from zero), shifted and saturated.
  always_comb begin
    rsum = prod_r + (sh24_r ? 64'd8388608 : 64'd32768);
    rq   = sh24_r ? DIV_BITS'(rsum >> 24) : DIV_BITS'(rsum >> 16);
    mv   = mag_sat(neg_r, rq);
  end

  // One restoring division step per lane, and the final rounding compare.
  always_comb begin
    t0     = {rem0_r, dd0_r[DIV_BITS-1]};
    t1     = {rem1_r, dd1_r[DIV_BITS-1]};
    ge0    = t0 >= {1'b0, 32'(s_r)};
    ge1    = t1 >= {1'b0, 32'(s_r)};
    two_r0 = {rem0_r, 1'b0};
    two_r1 = {rem1_r, 1'b0};
  end

  assign status.s_pos = !s_r[WORD_W-1] && (s_r != '0);

  // Configuration and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r    <= DEF_ANGLE_NOISE;
      qb_r    <= DEF_BIAS_NOISE;
      rm_r    <= DEF_MEASURE_NOISE;
      angle_r <= '0;
      bias_r  <= '0;
      p00_r   <= ONE_Q24;
      p01_r   <= '0;
      p10_r   <= '0;
      p11_r   <= ONE_Q24;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_NOISE:   qa_r <= cfg_wdata[NOISE_W-1:0];
        CFG_BIAS_NOISE:    qb_r <= cfg_wdata[NOISE_W-1:0];
        CFG_MEASURE_NOISE: rm_r <= cfg_wdata[NOISE_W-1:0];
        CFG_START_ANGLE: begin
          // A new start angle restarts the filter.
          angle_r <= word_t'(cfg_wdata);
          bias_r  <= '0;
          p00_r   <= ONE_Q24;
          p01_r   <= '0;
          p10_r   <= '0;
          p11_r   <= ONE_Q24;
        end
        default: ;
      endcase
    end else begin
      case (cmd.op)
        OP_ANGLE_ADD: angle_r <= sat_word(ext(angle_r) + ext(mv));
        OP_P00_ADD:   p00_r   <= sat_word(ext(p00_r) + ext(mv));
        OP_OFFDIAG: begin
          p01_r <= sat_word(ext(p01_r) - ext(dtp_r));
          p10_r <= sat_word(ext(p10_r) - ext(dtp_r));
        end
        OP_P11_ADD:   p11_r   <= sat_word(ext(p11_r) + ext(mv));
        OP_ANGLE_K:   angle_r <= sat_word(ext(angle_r) + ext(mv));
        OP_BIAS_K:    bias_r  <= sat_word(ext(bias_r) + ext(mv));
        OP_P10_K:     p10_r   <= sat_word(ext(p10_r) - ext(mv));
        OP_P11_K:     p11_r   <= sat_word(ext(p11_r) - ext(mv));
        OP_P00_K:     p00_r   <= sat_word(ext(p00_r) - ext(mv));
        OP_P01_K:     p01_r   <= sat_word(ext(p01_r) - ext(mv));
        default: ;
      endcase
    end
  end

  // Measurement capture, scratch values, multiplier and divider.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gyro_r  <= gyro_sample;
      accel_r <= accel_tilt;
      dt_r    <= time_step;
    end
    case (cmd.op)
      OP_RATE:  tmp_r <= sat_word(ext(gyro_r) - ext(bias_r));
      OP_DTP11: dtp_r <= mv;
      OP_INNER: tmp_r <= sat_word(ext(mv) - ext(p01_r) - ext(p10_r) + ext(qa_w));
      OP_INNOV: begin
        tmp_r <= sat_word(ext(accel_r) - ext(angle_r));
        s_r   <= sat_word(ext(p00_r) + ext(rm_w));
      end
      OP_DIV_INIT: begin
        dd0_r   <= {mag_word(p00_r), 24'd0};
        dd1_r   <= {mag_word(p10_r), 24'd0};
        dneg0_r <= p00_r[WORD_W-1];
        dneg1_r <= p10_r[WORD_W-1];
        rem0_r  <= '0;
        rem1_r  <= '0;
        quo0_r  <= '0;
        quo1_r  <= '0;
      end
      OP_DIV_STEP: begin
        dd0_r  <= {dd0_r[DIV_BITS-2:0], 1'b0};
        dd1_r  <= {dd1_r[DIV_BITS-2:0], 1'b0};
        rem0_r <= ge0 ? 32'(t0 - {1'b0, 32'(s_r)}) : t0[WORD_W-1:0];
        rem1_r <= ge1 ? 32'(t1 - {1'b0, 32'(s_r)}) : t1[WORD_W-1:0];
        quo0_r <= {quo0_r[DIV_BITS-2:0], ge0};
        quo1_r <= {quo1_r[DIV_BITS-2:0], ge1};
      end
      OP_DIV_ROUND: begin
        k0_r <= mag_sat(dneg0_r, quo0_r + DIV_BITS'(two_r0 >= {1'b0, 32'(s_r)}));
        k1_r <= mag_sat(dneg1_r, quo1_r + DIV_BITS'(two_r1 >= {1'b0, 32'(s_r)}));
      end
      OP_RESULT: begin
        out_angle_r <= angle_r;
        out_bias_r  <= bias_r;
      end
      default: ;
    endcase
    // The multiplier takes its operands in every cycle; only OP_M_* results are used.
    prod_r <= 64'(mag_word(mul_a)) * 64'(mag_word(mul_b));
    neg_r  <= mul_a[WORD_W-1] ^ mul_b[WORD_W-1];
    sh24_r <= mul_sh24;
  end

  assign angle_estimate = out_angle_r;
  assign drift_estimate = out_bias_r;

endmodule

/* rtl/core/kabf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter: controller
// Steps the datapath through prediction, gain division and correction, and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module kabf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  kabf_pkg::status_t   status,
  output kabf_pkg::cmd_t      cmd
);
  import kabf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_DIV,
    S_UPD,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;
  logic [DIVCNT_W-1:0] div_cnt_r;
  logic                out_valid_r;
  logic                in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Command decode from state and program step.
  always_comb begin
    cmd.load = in_fire;
    case (state_r)
      S_PRED:  cmd.op = pred_op(step_r);
      S_DIV:   cmd.op = OP_DIV_STEP;
      S_UPD:   cmd.op = upd_op(step_r);
      S_DONE:  cmd.op = (!out_valid_r || out_ready) ? OP_RESULT : OP_IDLE;
      default: cmd.op = OP_IDLE;
    endcase
  end

  // State, counters and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_PRED;
            step_r  <= '0;
          end
        end
        S_PRED: begin
          if (step_r == STEP_W'(PRED_LEN - 1)) begin
            step_r    <= '0;
            div_cnt_r <= '0;
            state_r   <= status.s_pos ? S_DIV : S_DONE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_DIV: begin
          if (div_cnt_r == DIVCNT_W'(DIV_BITS - 1)) begin
            state_r <= S_UPD;
            step_r  <= '0;
          end else begin
            div_cnt_r <= div_cnt_r + 1'b1;
          end
        end
        S_UPD: begin
          if (step_r == STEP_W'(UPD_LEN - 1)) begin
            state_r <= S_DONE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_DONE: begin
          if (cmd.op == OP_RESULT) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A new transaction always starts the prediction program.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_PRED) && (step_r == '0))
    else $error("accepted transaction did not start prediction");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> (cmd.op != OP_RESULT))
    else $error("result overwritten while still waiting");

  // Writing a result raises valid in the next cycle.
  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_RESULT) |=> out_valid_r)
    else $error("result written but valid not raised");

  // The divider only runs after a positive S was seen.
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRED && step_r == STEP_W'(PRED_LEN - 1) && !status.s_pos)
      |=> (state_r == S_DONE))
    else $error("correction entered with S not positive");

endmodule

/* rtl/core/kalman_angle_bias_filter.sv */
`timescale 1ns / 1ps
// The estimates become valid once prediction, gain division and correction are done;
// when S is not positive the division and the correction are skipped.
// A new measurement is taken only after the previous estimate has been written;
// the gains come from a 56-step restoring division, and one multiplier is shared.
// Reset is synchronous and active low: noise registers return to their defaults,
// the filter state to zero angle, zero bias and unit covariance.
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter: top level
// Two-state Kalman filter fusing gyro rate and accelerometer angle into angle
// and gyro bias estimates, built as a sequencer driving a shared datapath.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  kabf_in_if.sink                             in_ch,
  kabf_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [kabf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_wdata
);
  import kabf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer and handshakes.
  kabf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  kabf_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .gyro_sample    (in_ch.gyro_sample),
    .accel_tilt     (in_ch.accel_tilt),
    .time_step      (in_ch.time_step),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .angle_estimate (out_ch.angle_estimate),
    .drift_estimate (out_ch.drift_estimate)
  );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle and bias Kalman filter: self-checking testbench
// Drives measurement transactions with random gaps, stalls the estimate
// channel at random and checks every estimate against an in-bench fixed-point
// model of the filter. The run goes through several noise and start angle
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
  import kabf_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE       = 120;
  localparam longint WMAX     = 64'sd2147483647;
  localparam longint WMIN     = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] gyro;
    logic signed [31:0] accel;
    logic        [15:0] dt;
  } meas_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } est_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  kabf_in_if  in_ch ();
  kabf_out_if out_ch ();

  kalman_angle_bias_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Filter model state and registers.
  longint m_qa, m_qb, m_rm, m_start;
  longint m_angle, m_bias, m_p00, m_p01, m_p10, m_p11;

  meas_t  pending_meas[$];
  est_t   est_q[$];
  meas_t  cur;
  bit     busy;
  int     in_gap;
  int     out_gap;
  bit     no_idle;
  int     errors;
  int     checked;
  int     skipped;
  int     cycles;

  function automatic longint clamp(input longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  function automatic longint magn(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Apply a sign to a wide magnitude and saturate.
  function automatic longint signed_mag(input bit neg, input logic [127:0] m);
    longint r;
    if (neg) r = (m > 128'd2147483648) ? WMIN : -longint'(m[63:0]);
    else r = (m > 128'd2147483647) ? WMAX : longint'(m[63:0]);
    return r;
  endfunction

  // Rounded, saturated fixed-point product.
  function automatic longint fx_product(input longint a, input longint b, input int sh);
    logic [127:0] p;
    p = 128'(magn(a)) * 128'(magn(b)) + (128'd1 << (sh - 1));
    return signed_mag((a < 0) != (b < 0), p >> sh);
  endfunction

  // Rounded, saturated fixed-point quotient; d is positive.
  function automatic longint fx_quotient(input longint n, input longint d, input int sh);
    logic [127:0] num, q, r;
    num = 128'(magn(n)) << sh;
    q = num / 128'(d);
    r = num % 128'(d);
    if (2 * r >= 128'(d)) q = q + 1;
    return signed_mag(n < 0, q);
  endfunction

  task automatic restart_filter();
    m_angle = m_start;
    m_bias  = 0;
    m_p00   = ONE_Q24;
    m_p01   = 0;
    m_p10   = 0;
    m_p11   = ONE_Q24;
  endtask

  // One predict step and, when S is positive, correct step; the estimate joins the expected store.
  task automatic filter_step(input meas_t m);
    longint rate, dtp11, inner, y, s, k0, k1, p00, p01, dt;
    est_t e;
    dt = longint'(m.dt);
    rate = clamp(longint'(m.gyro) - m_bias);
    m_angle = clamp(m_angle + fx_product(dt, rate, 16));
    dtp11 = fx_product(dt, m_p11, 16);
    inner = clamp(fx_product(dt, dtp11, 16) - m_p01 - m_p10 + m_qa);
    m_p00 = clamp(m_p00 + fx_product(dt, inner, 16));
    m_p01 = clamp(m_p01 - dtp11);
    m_p10 = clamp(m_p10 - dtp11);
    m_p11 = clamp(m_p11 + fx_product(m_qb, dt, 16));
    y = clamp(longint'(m.accel) - m_angle);
    s = clamp(m_p00 + m_rm);
    if (s > 0) begin
      k0 = fx_quotient(m_p00, s, 24);
      k1 = fx_quotient(m_p10, s, 24);
      m_angle = clamp(m_angle + fx_product(k0, y, 24));
      m_bias = clamp(m_bias + fx_product(k1, y, 24));
      p00 = m_p00;
      p01 = m_p01;
      m_p00 = clamp(m_p00 - fx_product(k0, p00, 24));
      m_p01 = clamp(m_p01 - fx_product(k0, p01, 24));
      m_p10 = clamp(m_p10 - fx_product(k1, p00, 24));
      m_p11 = clamp(m_p11 - fx_product(k1, p01, 24));
    end else begin
      skipped++;
    end
    e.angle = m_angle[31:0];
    e.bias  = m_bias[31:0];
    est_q.push_back(e);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %0s: got %h, expected %h (estimate %0d)", what, got, want, checked);
    errors++;
  endtask

  // Clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Driver: presents queued measurements, with a random gap after each transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      busy = 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        filter_step(cur);
        busy = 1'b0;
        in_gap = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (!busy) begin
        if (in_gap > 0) in_gap--;
        else if (pending_meas.size() > 0) begin
          cur = pending_meas.pop_front();
          busy = 1'b1;
        end
      end
      in_ch.valid       <= busy;
      in_ch.gyro_sample <= cur.gyro;
      in_ch.accel_tilt  <= cur.accel;
      in_ch.time_step   <= cur.dt;
    end
  end

  // Monitor: random stalls on the estimate channel and a check per transaction.
  always @(posedge clk) begin
    est_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (est_q.size() == 0) begin
          note_mismatch("unexpected estimate", out_ch.angle_estimate, 32'h0);
        end else begin
          e = est_q.pop_front();
          if (out_ch.angle_estimate !== e.angle)
            note_mismatch("angle_estimate", out_ch.angle_estimate, e.angle);
          if (out_ch.drift_estimate !== e.bias)
            note_mismatch("drift_estimate", out_ch.drift_estimate, e.bias);
        end
        checked++;
        out_gap = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Register write; the model is updated as the write is driven, with the filter idle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ANGLE_NOISE:   m_qa = longint'(val[30:0]);
      CFG_BIAS_NOISE:    m_qb = longint'(val[30:0]);
      CFG_MEASURE_NOISE: m_rm = longint'(val[30:0]);
      CFG_START_ANGLE: begin
        m_start = longint'($signed(val));
        restart_filter();
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_meas.size() != 0 || busy || est_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_meas(input logic [31:0] g, input logic [31:0] a, input logic [15:0] d);
    meas_t m;
    m.gyro = g;
    m.accel = a;
    m.dt = d;
    pending_meas.push_back(m);
  endtask

  // Mostly plausible IMU samples, with some full-range noise.
  task automatic push_random(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7)
        push_meas(32'($signed($urandom_range(0, 400 << 16)) - (200 << 16)),
                  32'($signed($urandom_range(0, 180 << 16)) - (90 << 16)),
                  16'($urandom_range(100, 3000)));
      else
        push_meas($urandom, $urandom, 16'($urandom));
    end
  endtask

  initial begin
    int ph;
    errors = 0;
    checked = 0;
    skipped = 0;
    cycles = 0;
    no_idle = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.gyro_sample = '0;
    in_ch.accel_tilt = '0;
    in_ch.time_step = '0;
    out_ch.ready = 1'b0;
    m_qa = DEF_ANGLE_NOISE;
    m_qb = DEF_BIAS_NOISE;
    m_rm = DEF_MEASURE_NOISE;
    m_start = 0;
    restart_filter();
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes at the default settings.
    push_meas(32'h0, 32'h0, 16'h0);
    push_meas(32'h7fffffff, 32'h7fffffff, 16'hffff);
    push_meas(32'h80000000, 32'h80000000, 16'hffff);
    push_meas(32'h7fffffff, 32'h80000000, 16'h0001);
    push_meas(32'h80000000, 32'h7fffffff, 16'h8000);
    push_meas(32'hffffffff, 32'h00000001, 16'hffff);
    push_meas(32'h00010000, 32'h000a0000, 16'd655);
    push_meas(32'h0, 32'h0, 16'hffff);
    push_meas(32'h0, 32'h0, 16'hffff);
    push_meas(32'h7fffffff, 32'h0, 16'hffff);
    wait_idle();

    // Directed: saturated covariance so that S stops being positive.
    cfg_write(CFG_ANGLE_NOISE, 32'h7fffffff);
    cfg_write(CFG_MEASURE_NOISE, 32'h7fffffff);
    push_meas(32'h80000000, 32'h7fffffff, 16'hffff);
    push_meas(32'h7fffffff, 32'h80000000, 16'hffff);
    push_meas(32'h12345678, 32'hedcba987, 16'hffff);
    push_meas(32'h0, 32'h0, 16'hffff);
    wait_idle();
    cfg_write(CFG_MEASURE_NOISE, 32'h0);
    cfg_write(CFG_BIAS_NOISE, 32'h7fffffff);
    cfg_write(3'd5, 32'hffffffff);
    push_meas(32'h0, 32'h0, 16'hffff);
    push_meas(32'h7fffffff, 32'h7fffffff, 16'h0);
    push_meas(32'h80000000, 32'h0, 16'hffff);
    wait_idle();

    // Random phases over a spread of settings.
    for (ph = 0; ph < 8; ph++) begin
      no_idle = (ph % 4 == 3);
      case (ph)
        0: begin
          cfg_write(CFG_ANGLE_NOISE, 32'(DEF_ANGLE_NOISE));
          cfg_write(CFG_BIAS_NOISE, 32'(DEF_BIAS_NOISE));
          cfg_write(CFG_MEASURE_NOISE, 32'(DEF_MEASURE_NOISE));
          cfg_write(CFG_START_ANGLE, 32'h0);
        end
        1: begin
          cfg_write(CFG_ANGLE_NOISE, 32'h0);
          cfg_write(CFG_BIAS_NOISE, 32'h0);
          cfg_write(CFG_MEASURE_NOISE, 32'h1);
          cfg_write(CFG_START_ANGLE, 32'h80000000);
        end
        2: begin
          cfg_write(CFG_ANGLE_NOISE, 32'h7fffffff);
          cfg_write(CFG_BIAS_NOISE, 32'h7fffffff);
          cfg_write(CFG_MEASURE_NOISE, 32'h7fffffff);
          cfg_write(CFG_START_ANGLE, 32'h7fffffff);
        end
        default: begin
          cfg_write(CFG_ANGLE_NOISE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
          cfg_write(CFG_BIAS_NOISE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
          cfg_write(CFG_MEASURE_NOISE, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1 << 24));
          cfg_write(CFG_START_ANGLE, $urandom);
          cfg_write(3'($urandom_range(4, 7)), $urandom);
        end
      endcase
      push_random(140);
      wait_idle();
    end

    $display("covered %0d estimates across 8 random phases and directed extremes", checked);
    $display("%0d updates took the path without correction", skipped);
    if (errors == 0 && est_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d estimates outstanding", errors, est_q.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
